// ===== sv/dgsp_pkg.sv =====
// Shared constants and types for the dense graph shortest path unit.
package dgsp_pkg;

	localparam int NODES       = 64;
	localparam int NODE_W      = $clog2(NODES);
	localparam int CNT_W       = $clog2(NODES + 1);
	localparam int EDGE_AW     = 2 * NODE_W;
	localparam int EDGE_DEPTH  = NODES * NODES;
	localparam int WEIGHT_W    = 24;
	localparam int DIST_W      = 32;
	localparam int MAX_RESULTS = 64;
	localparam int STEP_W      = 6;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PICK,
		S_DECIDE,
		S_RELAX,
		S_FINISH,
		S_RESULT,
		S_PRED
	} state_t;

endpackage

// ===== sv/dense_graph_shortest_path_unit.sv =====
// Dense adjacency-matrix shortest path engine with a scanning sequencer.
//
// A write transaction (operation = 0) stores one edge weight in a 64 x 64 matrix RAM; a weight
// of zero means no edge, and the whole matrix must be loaded before queries are issued. A query
// transaction (operation = 1) runs a shortest path search from from_node to to_node and then
// returns the path from the destination back to the source, one result per node, with last set
// on the source (or on the 64th result of a longer path). An unreachable destination gives a
// single result with found = 0. Each search round scans all node distances once through the
// distance RAM read port to pick the next node, then in a decision state ends the search if
// that node is the destination and otherwise, if the node was reached, sweeps its matrix row
// through the edge RAM and one saturating adder. The unit takes no new transaction during a
// query; the final result of a query may still be waiting in the output register when the
// next transaction is taken.
module dense_graph_shortest_path_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic                           operation,
	input  logic [dgsp_pkg::NODE_W-1:0]    from_node,
	input  logic [dgsp_pkg::NODE_W-1:0]    to_node,
	input  logic [dgsp_pkg::WEIGHT_W-1:0]  weight,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [dgsp_pkg::NODE_W-1:0]    node,
	output logic [dgsp_pkg::STEP_W-1:0]    step,
	output logic                           found,
	output logic                           last
);

	import dgsp_pkg::*;

	state_t state_q, state_d;

	logic [NODE_W-1:0]   src_q, dst_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NODE_W-1:0]   round_q;
	logic                v_s1;
	logic [NODE_W-1:0]   idx_s1;
	logic [NODES-1:0]    visited_q, reached_q;
	logic                have_q;
	logic [NODE_W-1:0]   best_q;
	logic                best_reached_q;
	logic [DIST_W-1:0]   best_dist_q;
	logic [NODE_W-1:0]   cur_q;
	logic [STEP_W-1:0]   k_q;

	logic                res_valid_q;
	logic [NODE_W-1:0]   node_q;
	logic [STEP_W-1:0]   step_q;
	logic                found_q, last_q;

	logic                item_acc, q_start, edge_we;
	logic                issue, scan_end, take, more_rounds, round_done, out_free;
	logic [WEIGHT_W-1:0] edge_rd;
	logic [DIST_W-1:0]   dist_rd;
	logic [NODE_W-1:0]   pred_rd;
	logic [DIST_W:0]     sum;
	logic [DIST_W-1:0]   nd;
	logic                relax_upd;
	logic                dist_we;
	logic [NODE_W-1:0]   dist_waddr;
	logic [DIST_W-1:0]   dist_wdata;

	logic                load_out, load_found, load_last;
	logic [NODE_W-1:0]   load_node;
	logic [STEP_W-1:0]   load_step;

	assign item_ready = (state_q == S_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign q_start    = item_acc && (operation == OP_QUERY);
	assign edge_we    = item_acc && (operation == OP_WRITE);

	assign issue    = ((state_q == S_PICK) || (state_q == S_RELAX)) && (cnt_q < CNT_W'(NODES));
	assign scan_end = v_s1 && (idx_s1 == NODE_W'(NODES - 1));
	assign out_free = !res_valid_q || result_ready;
	// The loop runs rounds 0 .. NODES-2.
	assign more_rounds = (round_q != NODE_W'(NODES - 2));

	// Pick: least reached distance wins, ties to the later index; unreached nodes rank last.
	always_comb begin
		take = 1'b0;
		if (state_q == S_PICK && v_s1 && !visited_q[idx_s1]) begin
			if (!have_q) begin
				take = 1'b1;
			end else if (reached_q[idx_s1]) begin
				take = !best_reached_q || (dist_rd <= best_dist_q);
			end else begin
				take = !best_reached_q;
			end
		end
	end

	// Relax: saturating sum of the picked node's distance and the edge weight.
	assign sum = {1'b0, best_dist_q} + (DIST_W + 1)'(edge_rd);
	assign nd  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	assign relax_upd = (state_q == S_RELAX) && v_s1 && !visited_q[idx_s1]
		&& (edge_rd != '0) && (!reached_q[idx_s1] || (nd < dist_rd));

	assign dist_we    = q_start || relax_upd;
	assign dist_waddr = q_start ? from_node : idx_s1;
	assign dist_wdata = q_start ? '0 : nd;

	dgsp_ram #(.WIDTH(WEIGHT_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr ({from_node, to_node}),
		.wdata (weight),
		.raddr ({best_q, cnt_q[NODE_W-1:0]}),
		.rdata (edge_rd)
	);

	dgsp_ram #(.WIDTH(DIST_W), .DEPTH(NODES)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (cnt_q[NODE_W-1:0]),
		.rdata (dist_rd)
	);

	// The read address follows the path cursor, so the predecessor is ready in the cycle after the cursor changes.
	dgsp_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_pred_ram (
		.clk   (clk),
		.we    (relax_upd),
		.waddr (idx_s1),
		.wdata (best_q),
		.raddr (cur_q),
		.rdata (pred_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		round_done = 1'b0;
		load_out   = 1'b0;
		load_node  = cur_q;
		load_step  = k_q;
		load_found = 1'b1;
		load_last  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_start) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (scan_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (best_q == dst_q) begin
					state_d = S_FINISH;
				end else if (!best_reached_q) begin
					round_done = 1'b1;
					state_d    = more_rounds ? S_PICK : S_FINISH;
				end else begin
					state_d = S_RELAX;
				end
			end
			S_RELAX: begin
				if (scan_end) begin
					round_done = 1'b1;
					state_d    = more_rounds ? S_PICK : S_FINISH;
				end
			end
			S_FINISH: begin
				if ((src_q != dst_q) && !reached_q[dst_q]) begin
					if (out_free) begin
						load_out   = 1'b1;
						load_node  = dst_q;
						load_step  = '0;
						load_found = 1'b0;
						load_last  = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_last = (cur_q == src_q) || (k_q == STEP_W'(MAX_RESULTS - 1));
					state_d   = load_last ? S_IDLE : S_PRED;
				end
			end
			S_PRED: begin
				state_d = S_RESULT;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			round_q     <= '0;
			have_q      <= 1'b0;
			visited_q   <= '0;
			reached_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= issue;

			if (state_d == S_PICK && state_q != S_PICK) begin
				have_q <= 1'b0;
			end else if (take) begin
				have_q <= 1'b1;
			end

			if (q_start) begin
				round_q <= '0;
			end else if (round_done) begin
				round_q <= round_q + 1'b1;
			end

			if (q_start) begin
				visited_q <= '0;
			end else if (state_q == S_DECIDE && best_q != dst_q) begin
				visited_q[best_q] <= 1'b1;
			end

			// A new query starts with only its source reached.
			if (q_start) begin
				reached_q <= {{(NODES-1){1'b0}}, 1'b1} << from_node;
			end else if (relax_upd) begin
				reached_q[idx_s1] <= 1'b1;
			end

			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (q_start) begin
			src_q <= from_node;
			dst_q <= to_node;
		end
		idx_s1 <= cnt_q[NODE_W-1:0];
		if (take) begin
			best_q         <= idx_s1;
			best_reached_q <= reached_q[idx_s1];
			best_dist_q    <= dist_rd;
		end
		if (state_q == S_FINISH) begin
			cur_q <= dst_q;
			k_q   <= '0;
		end else if (state_q == S_PRED) begin
			cur_q <= pred_rd;
			k_q   <= k_q + 1'b1;
		end
		if (load_out) begin
			node_q  <= load_node;
			step_q  <= load_step;
			found_q <= load_found;
			last_q  <= load_last;
		end
	end

	assign result_valid = res_valid_q;
	assign node         = node_q;
	assign step         = step_q;
	assign found        = found_q;
	assign last         = last_q;

	a_src_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> reached_q[src_q])
		else $error("source lost its reached flag during a query");

	a_visit_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && best_q != dst_q) |=> visited_q[$past(best_q)])
		else $error("picked node not marked visited");

	a_relax_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RELAX) |-> best_reached_q)
		else $error("relaxing from an unreached node");

	a_path_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |-> reached_q[cur_q])
		else $error("path walk reached a node outside the search tree");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !v_s1)
		else $error("scan still in flight while taking a transaction");

endmodule

// ===== sv/dgsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dgsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sim/dense_graph_shortest_path_unit_tb.sv =====
// Self-checking testbench for the dense graph shortest path unit.
`timescale 1ns / 100ps

module dense_graph_shortest_path_unit_tb;

	import dgsp_pkg::*;

	localparam int LIMIT_CYCLES = 6000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 140;

	typedef struct packed {
		op_t                 op;
		logic [NODE_W-1:0]   src;
		logic [NODE_W-1:0]   dst;
		logic [WEIGHT_W-1:0] w;
		logic                drain;
		logic                calm;
	} graph_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [STEP_W-1:0] step;
		logic              found;
		logic              last;
	} path_rec_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	logic                operation    = 1'b0;
	logic [NODE_W-1:0]   from_node    = '0;
	logic [NODE_W-1:0]   to_node      = '0;
	logic [WEIGHT_W-1:0] weight       = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [NODE_W-1:0]   node;
	logic [STEP_W-1:0]   step;
	logic                found;
	logic                last;

	graph_item_t pending[$];
	graph_item_t next_item;
	path_rec_t   path_q[$];
	path_rec_t   got_rec;
	path_rec_t   want_rec;

	// Predictor state: the edge matrix and the per-query search arrays.
	logic [WEIGHT_W-1:0] adj_w  [0:EDGE_DEPTH-1];
	logic [DIST_W-1:0]   cost   [0:NODES-1];
	bit                  reach  [0:NODES-1];
	bit                  done_f [0:NODES-1];
	logic [NODE_W-1:0]   pred   [0:NODES-1];

	logic calm_now   = 1'b0;
	int   hold_left  = 0;
	bit   hold_used  = 1'b0;
	int   mismatches = 0;
	int   cycles     = 0;

	dense_graph_shortest_path_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.from_node    (from_node),
		.to_node      (to_node),
		.weight       (weight),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.node         (node),
		.step         (step),
		.found        (found),
		.last         (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic path_rec_t path_rec(input logic [NODE_W-1:0] n, input logic [STEP_W-1:0] s,
		input logic f, input logic l);
		path_rec_t rec;
		rec.node  = n;
		rec.step  = s;
		rec.found = f;
		rec.last  = l;
		return rec;
	endfunction

	task automatic add_item(input op_t op, input int src, input int dst, input logic [WEIGHT_W-1:0] w,
		input logic drain, input logic calm);
		graph_item_t it;
		it.op    = op;
		it.src   = src[NODE_W-1:0];
		it.dst   = dst[NODE_W-1:0];
		it.w     = w;
		it.drain = drain;
		it.calm  = calm;
		pending.push_back(it);
	endtask

	// Applies one accepted transaction to the predictor and queues the path it yields.
	task automatic predict_path(input logic op, input logic [NODE_W-1:0] src,
		input logic [NODE_W-1:0] dst, input logic [WEIGHT_W-1:0] w);
		int r, u, v, k;
		bit have, best_reach;
		logic [DIST_W-1:0] best_cost;
		logic [DIST_W:0] sum;
		logic [DIST_W-1:0] nd;
		logic [NODE_W-1:0] cur;
		if (op == OP_WRITE) begin
			adj_w[{src, dst}] = w;
			return;
		end
		for (v = 0; v < NODES; v++) begin
			done_f[v] = 1'b0;
			reach[v]  = 1'b0;
			cost[v]   = '0;
		end
		reach[src] = 1'b1;
		for (r = 0; r + 1 < NODES; r++) begin
			u = 0;
			have = 1'b0;
			best_reach = 1'b0;
			best_cost = '0;
			// Reached nodes rank above unreached ones; ties go to the highest index.
			for (v = 0; v < NODES; v++) begin
				if (!done_f[v]) begin
					if (!have) begin
						u = v;
						best_reach = reach[v];
						best_cost = cost[v];
						have = 1'b1;
					end else if (reach[v]) begin
						if (!best_reach || cost[v] <= best_cost) begin
							u = v;
							best_reach = 1'b1;
							best_cost = cost[v];
						end
					end else if (!best_reach) begin
						u = v;
					end
				end
			end
			if (u == dst)
				break;
			done_f[u] = 1'b1;
			if (reach[u]) begin
				for (v = 0; v < NODES; v++) begin
					if (!done_f[v] && adj_w[u * NODES + v] != '0) begin
						sum = {1'b0, cost[u]} + adj_w[u * NODES + v];
						nd = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
						if (!reach[v] || nd < cost[v]) begin
							cost[v]  = nd;
							reach[v] = 1'b1;
							pred[v]  = u[NODE_W-1:0];
						end
					end
				end
			end
		end
		if (src != dst && !reach[dst]) begin
			path_q.push_back(path_rec(dst, '0, 1'b0, 1'b1));
		end else begin
			cur = dst;
			k = 0;
			while (cur != src && k < MAX_RESULTS - 1) begin
				path_q.push_back(path_rec(cur, k[STEP_W-1:0], 1'b1, 1'b0));
				cur = pred[cur];
				k++;
			end
			path_q.push_back(path_rec(cur, k[STEP_W-1:0], 1'b1, 1'b1));
		end
	endtask

	// Driver: predicts each accepted transaction, then offers the next pending one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				predict_path(operation, from_node, to_node, weight);
			if (!item_valid || item_ready) begin
				if (pending.size() != 0 && !(pending[0].drain && path_q.size() != 0) &&
					(pending[0].calm || $urandom_range(99) >= 31)) begin
					next_item = pending.pop_front();
					operation  <= next_item.op;
					from_node  <= next_item.src;
					to_node    <= next_item.dst;
					weight     <= next_item.w;
					calm_now   <= next_item.calm;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started by the first result ever offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (!hold_used && result_valid) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compares each accepted result with the oldest expected path entry.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				got_rec = path_rec(node, step, found, last);
				if (path_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result node %0d step %0d found %0d last %0d",
						node, step, found, last));
				end else begin
					want_rec = path_q.pop_front();
					if (got_rec.node != want_rec.node)
						report_mismatch($sformatf("node %0d, expected %0d", got_rec.node, want_rec.node));
					if (got_rec.step != want_rec.step)
						report_mismatch($sformatf("step %0d, expected %0d", got_rec.step, want_rec.step));
					if (got_rec.found != want_rec.found)
						report_mismatch($sformatf("found %0d, expected %0d", got_rec.found,
							want_rec.found));
					if (got_rec.last != want_rec.last)
						report_mismatch($sformatf("last %0d, expected %0d", got_rec.last, want_rec.last));
				end
			end
			result_ready <= (hold_left == 0) && (calm_now || $urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int i, u, v, roll, src, dst;
		logic [WEIGHT_W-1:0] w;
		logic calm_bit;

		// Load the whole matrix first: a chain 0 -> 1 -> ... -> 63 at the largest weight.
		for (u = 0; u < NODES; u++)
			for (v = 0; v < NODES; v++)
				add_item(OP_WRITE, u, v, (v == u + 1) ? {WEIGHT_W{1'b1}} : '0, 1'b0, 1'b0);

		// Directed part.
		add_item(OP_QUERY, 0, 63, '0, 1'b0, 1'b0);          // longest path, 64 results
		add_item(OP_QUERY, 5, 5, '0, 1'b0, 1'b0);           // source equals destination
		add_item(OP_QUERY, 63, 0, '0, 1'b0, 1'b0);          // unreachable destination
		add_item(OP_QUERY, 0, 0, '0, 1'b0, 1'b0);
		add_item(OP_WRITE, 0, 63, 24'h000001, 1'b0, 1'b0);  // shortcut with the least weight
		add_item(OP_QUERY, 0, 63, '0, 1'b0, 1'b0);
		add_item(OP_WRITE, 0, 63, '0, 1'b0, 1'b0);
		add_item(OP_WRITE, 63, 63, {WEIGHT_W{1'b1}}, 1'b0, 1'b0);
		add_item(OP_WRITE, 63, 0, 24'h000100, 1'b0, 1'b0);
		add_item(OP_QUERY, 63, 1, '0, 1'b0, 1'b0);
		// Two equal-cost routes from 10 to 40 exercise the tie rules.
		add_item(OP_WRITE, 10, 20, 24'h000008, 1'b0, 1'b0);
		add_item(OP_WRITE, 10, 30, 24'h000008, 1'b0, 1'b0);
		add_item(OP_WRITE, 20, 40, 24'h000008, 1'b0, 1'b0);
		add_item(OP_WRITE, 30, 40, 24'h000008, 1'b0, 1'b0);
		add_item(OP_QUERY, 10, 40, '0, 1'b0, 1'b0);
		add_item(OP_WRITE, 30, 40, 24'h000007, 1'b0, 1'b0);
		add_item(OP_QUERY, 10, 40, '0, 1'b0, 1'b0);
		add_item(OP_QUERY, 40, 10, '0, 1'b0, 1'b0);
		add_item(OP_QUERY, 63, 63, '0, 1'b0, 1'b0);

		// Random part; the sender waits for every expected result before the first
		// random transaction and again before random item 100.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm_bit = (i >= 30 && i < 75);
			roll = $urandom_range(99);
			src = $urandom_range(NODES - 1);
			dst = $urandom_range(NODES - 1);
			if (roll < 55) begin
				roll = $urandom_range(99);
				if (roll < 35)
					w = '0;
				else if (roll < 55)
					w = WEIGHT_W'($urandom_range(255, 1));
				else if (roll < 65)
					w = {WEIGHT_W{1'b1}};
				else
					w = WEIGHT_W'($urandom());
				add_item(OP_WRITE, src, dst, w, (i == 0 || i == 100), calm_bit);
			end else begin
				if ($urandom_range(9) == 0)
					dst = src;
				add_item(OP_QUERY, src, dst, WEIGHT_W'($urandom()), (i == 0 || i == 100),
					calm_bit);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || item_valid)
			@(posedge clk);
		while (path_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
